### design/radial_swirl_pixel_color_top_defines.svh
// assertion helpers for the swirl pixel pipeline
`ifndef RADIAL_SWIRL_PIXEL_COLOR_TOP_DEFINES_SVH
`define RADIAL_SWIRL_PIXEL_COLOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RSWIRL_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RSWIRL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rswirl_pkg.sv
`default_nettype none
package rswirl_pkg;

   localparam int unsigned LedCountDefault = 1024;
   localparam int unsigned CordicSteps     = 14;
   localparam int unsigned SqrtSteps       = 18;
   localparam int unsigned SqrtWidth       = 2 * SqrtSteps - 1;
   localparam int unsigned DivSteps        = 8;
   localparam int unsigned Channels        = 3;

   localparam logic [15:0] ThirdTurn     = 16'd21845;
   localparam logic [15:0] TwoThirdsTurn = 16'd43691;
   localparam logic [15:0] HalfTurn      = 16'd32768;
   localparam logic [15:0] FoldMask      = 16'h8000;

   localparam logic signed [16:0] SineGain = 17'sd9949;
   localparam logic signed [16:0] OneQ14   = 17'sd16384;
   localparam logic [7:0] ChanMax = 8'd254;

   // register reset values
   localparam logic [7:0]  CenterRowReset = 8'd0;
   localparam logic [7:0]  CenterColReset = 8'd0;
   localparam logic [7:0]  RadiusReset    = 8'd10;
   localparam logic [15:0] PhaseStepReset = 16'd2608;

   typedef enum logic [1:0] {
      CSR_CENTER_ROW   = 2'd0,
      CSR_CENTER_COL   = 2'd1,
      CSR_SWIRL_RADIUS = 2'd2,
      CSR_PHASE_STEP   = 2'd3
   } csr_index_type;

   typedef logic [15:0]        turn_type;
   typedef logic signed [19:0] vec_type;
   typedef logic signed [16:0] sin_type;
   typedef logic [SqrtWidth-1:0] root_type;

   // arctangent of 2^-i in turns * 65536
   function automatic turn_type atan_turn(input int unsigned i);
      turn_type v;
      case (i)
         0:       v = 16'd8192;
         1:       v = 16'd4836;
         2:       v = 16'd2555;
         3:       v = 16'd1297;
         4:       v = 16'd651;
         5:       v = 16'd326;
         6:       v = 16'd163;
         7:       v = 16'd81;
         8:       v = 16'd41;
         9:       v = 16'd20;
         10:      v = 16'd10;
         11:      v = 16'd5;
         12:      v = 16'd3;
         13:      v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // phase offset of each color channel
   function automatic turn_type chan_offset(input int unsigned c);
      turn_type v;
      case (c)
         1:       v = ThirdTurn;
         2:       v = TwoThirdsTurn;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### design/radial_swirl_pixel_color_top.sv
// radial swirl pixel color
// req channel: one pixel per item; req_tuser is frame_start, which steps the
// phase accumulator by phase_step before this pixel is colored.
// rsp channel: one item per pixel with the led number and the rgb color.
// csr port: csr_we writes csr_wdata to the register at csr_index
// (center_row, center_col, swirl_radius, phase_step); write only while idle.
// throughput: one item per cycle unless the output stalls; the path is a
// straight pipeline of 18 square root stages, 14 atan stages in parallel,
// 14 sine stages per channel, a multiply and scale and an 8 stage
// restoring divide by radius.
// stall: when rsp_tvalid is high and rsp_tready low the whole pipeline
// holds and req_tready drops; nothing is lost or repeated.
// reset: all valid bits clear, phase goes to zero, registers take their
// defaults (center 0,0, radius 10, phase step 2608).
`default_nettype none
`include "radial_swirl_pixel_color_top_defines.svh"
module radial_swirl_pixel_color_top
   import rswirl_pkg::*;
#(
   parameter int unsigned LED_COUNT = LedCountDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pixel_row, pixel_col, led_index, zero pad
   input  wire logic [31:0] req_tdata,
   // frame_start
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // led_number, red, green, blue, zero pad
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic adv;

   // configuration registers
   logic [7:0]  center_row_ff, center_col_ff, radius_ff;
   logic [15:0] phase_step_ff;
   turn_type    phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_row_ff <= CenterRowReset;
         center_col_ff <= CenterColReset;
         radius_ff     <= RadiusReset;
         phase_step_ff <= PhaseStepReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_ROW:   center_row_ff <= csr_wdata[7:0];
            CSR_CENTER_COL:   center_col_ff <= csr_wdata[7:0];
            CSR_SWIRL_RADIUS: radius_ff     <= csr_wdata[7:0];
            CSR_PHASE_STEP:   phase_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // phase accumulator, steps on a frame start item
   turn_type phase_in;
   assign phase_in = req_tuser ? phase_ff + phase_step_ff : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (req_tvalid && adv && req_tuser) begin
         phase_ff <= phase_in;
      end
   end

   // entry stage: offsets from the center
   logic              s0_v_ff, s0_inr_ff;
   logic signed [8:0] s0_dx_ff, s0_dy_ff;
   turn_type          s0_phase_ff;
   logic [9:0]        s0_led_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff     <= req_tvalid;
         s0_dx_ff    <= $signed({1'b0, req_tdata[7:0]}) - $signed({1'b0, center_row_ff});
         s0_dy_ff    <= $signed({1'b0, req_tdata[15:8]}) - $signed({1'b0, center_col_ff});
         s0_phase_ff <= phase_in;
         s0_led_ff   <= req_tdata[25:16];
         s0_inr_ff   <= (32'(req_tdata[25:16]) < LED_COUNT);
      end
   end

   // front pipeline: square root and atan side by side
   root_type   sq_n_ff   [0:SqrtSteps];
   root_type   sq_res_ff [0:SqrtSteps];
   vec_type    at_x_ff   [0:SqrtSteps];
   vec_type    at_y_ff   [0:SqrtSteps];
   turn_type   at_z_ff   [0:SqrtSteps];
   turn_type   fr_base_ff  [0:SqrtSteps];
   logic       fr_ctr_ff   [0:SqrtSteps];
   turn_type   fr_phase_ff [0:SqrtSteps];
   logic [9:0] fr_led_ff   [0:SqrtSteps];
   logic       fr_inr_ff   [0:SqrtSteps];
   logic       fr_v_ff     [0:SqrtSteps];

   // squared distance and cordic start vector
   logic signed [17:0] dx_sq, dy_sq;
   logic [16:0]        d2;
   vec_type            x0, y0;

   always_comb begin
      dx_sq = s0_dx_ff * s0_dx_ff;
      dy_sq = s0_dy_ff * s0_dy_ff;
      d2    = 17'(dx_sq) + 17'(dy_sq);
      x0    = vec_type'(s0_dx_ff) <<< 8;
      y0    = vec_type'(s0_dy_ff) <<< 8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_v_ff[0] <= 1'b0;
      end else if (adv) begin
         fr_v_ff[0]     <= s0_v_ff;
         sq_n_ff[0]     <= SqrtWidth'({d2, 16'd0});
         sq_res_ff[0]   <= '0;
         at_x_ff[0]     <= (x0 < 0) ? -x0 : x0;
         at_y_ff[0]     <= (x0 < 0) ? -y0 : y0;
         at_z_ff[0]     <= '0;
         fr_base_ff[0]  <= (x0 < 0) ? HalfTurn : '0;
         fr_ctr_ff[0]   <= (s0_dx_ff == 9'sd0) && (s0_dy_ff == 9'sd0);
         fr_phase_ff[0] <= s0_phase_ff;
         fr_led_ff[0]   <= s0_led_ff;
         fr_inr_ff[0]   <= s0_inr_ff;
      end
   end

   for (genvar gj = 0; gj < SqrtSteps; gj++) begin : g_front
      localparam int unsigned Shift = SqrtWidth - 1 - 2 * gj;
      root_type sq_one, sq_trial;
      logic     sq_take;

      // one result bit per stage
      always_comb begin
         sq_one   = root_type'(1) << Shift;
         sq_trial = sq_res_ff[gj] + sq_one;
         sq_take  = (sq_n_ff[gj] >= sq_trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fr_v_ff[gj+1] <= 1'b0;
         end else if (adv) begin
            fr_v_ff[gj+1]     <= fr_v_ff[gj];
            sq_n_ff[gj+1]     <= sq_take ? sq_n_ff[gj] - sq_trial : sq_n_ff[gj];
            sq_res_ff[gj+1]   <= sq_take ? (sq_res_ff[gj] >> 1) + sq_one
                                         : sq_res_ff[gj] >> 1;
            fr_base_ff[gj+1]  <= fr_base_ff[gj];
            fr_ctr_ff[gj+1]   <= fr_ctr_ff[gj];
            fr_phase_ff[gj+1] <= fr_phase_ff[gj];
            fr_led_ff[gj+1]   <= fr_led_ff[gj];
            fr_inr_ff[gj+1]   <= fr_inr_ff[gj];
         end
      end

      if (gj < CordicSteps) begin : g_atan
         // vectoring step, drives y toward zero
         vec_type xs, ys;
         always_comb begin
            xs = at_x_ff[gj] >>> gj;
            ys = at_y_ff[gj] >>> gj;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               if (at_y_ff[gj] >= 0) begin
                  at_x_ff[gj+1] <= at_x_ff[gj] + ys;
                  at_y_ff[gj+1] <= at_y_ff[gj] - xs;
                  at_z_ff[gj+1] <= at_z_ff[gj] + atan_turn(gj);
               end else begin
                  at_x_ff[gj+1] <= at_x_ff[gj] - ys;
                  at_y_ff[gj+1] <= at_y_ff[gj] + xs;
                  at_z_ff[gj+1] <= at_z_ff[gj] - atan_turn(gj);
               end
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (adv) begin
               at_x_ff[gj+1] <= at_x_ff[gj];
               at_y_ff[gj+1] <= at_y_ff[gj];
               at_z_ff[gj+1] <= at_z_ff[gj];
            end
         end
      end
   end

   // middle stage: falloff from the edge and final angle
   logic       md_v_ff, md_on_ff;
   turn_type   md_ang_ff;
   logic [15:0] md_fall_ff;
   logic [9:0] md_led_ff;
   root_type   edge_w;
   logic [15:0] fall_w;
   turn_type   ang_w;

   always_comb begin
      edge_w = root_type'({radius_ff, 8'd0});
      fall_w = (edge_w > sq_res_ff[SqrtSteps]) ? 16'(edge_w - sq_res_ff[SqrtSteps]) : 16'd0;
      ang_w  = (fr_ctr_ff[SqrtSteps] ? 16'd0
                : fr_base_ff[SqrtSteps] + at_z_ff[SqrtSteps]) + fr_phase_ff[SqrtSteps];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         md_v_ff <= 1'b0;
      end else if (adv) begin
         md_v_ff    <= fr_v_ff[SqrtSteps];
         md_on_ff   <= (fall_w != 16'd0) && fr_inr_ff[SqrtSteps];
         md_ang_ff  <= ang_w;
         md_fall_ff <= fall_w;
         md_led_ff  <= fr_led_ff[SqrtSteps];
      end
   end

   // sine pipeline, shared side fields
   logic        sn_v_ff    [0:CordicSteps];
   logic        sn_on_ff   [0:CordicSteps];
   logic [15:0] sn_fall_ff [0:CordicSteps];
   logic [9:0]  sn_led_ff  [0:CordicSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         sn_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sn_v_ff[0]    <= md_v_ff;
         sn_on_ff[0]   <= md_on_ff;
         sn_fall_ff[0] <= md_fall_ff;
         sn_led_ff[0]  <= md_led_ff;
      end
   end

   for (genvar gk = 0; gk < CordicSteps; gk++) begin : g_sn_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sn_v_ff[gk+1] <= 1'b0;
         end else if (adv) begin
            sn_v_ff[gk+1]    <= sn_v_ff[gk];
            sn_on_ff[gk+1]   <= sn_on_ff[gk];
            sn_fall_ff[gk+1] <= sn_fall_ff[gk];
            sn_led_ff[gk+1]  <= sn_led_ff[gk];
         end
      end
   end

   // tail side fields: lift, product, scale and divide stages
   logic       lf_v_ff, lf_on_ff, mu_v_ff, mu_on_ff;
   logic [15:0] lf_fall_ff;
   logic [9:0] lf_led_ff, mu_led_ff;
   logic       dv_v_ff   [0:DivSteps];
   logic       dv_on_ff  [0:DivSteps];
   logic [9:0] dv_led_ff [0:DivSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_v_ff    <= 1'b0;
         mu_v_ff    <= 1'b0;
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         lf_v_ff      <= sn_v_ff[CordicSteps];
         lf_on_ff     <= sn_on_ff[CordicSteps];
         lf_fall_ff   <= sn_fall_ff[CordicSteps];
         lf_led_ff    <= sn_led_ff[CordicSteps];
         mu_v_ff      <= lf_v_ff;
         mu_on_ff     <= lf_on_ff;
         mu_led_ff    <= lf_led_ff;
         dv_v_ff[0]   <= mu_v_ff;
         dv_on_ff[0]  <= mu_on_ff;
         dv_led_ff[0] <= mu_led_ff;
      end
   end

   for (genvar gd = 0; gd < DivSteps; gd++) begin : g_dv_side
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[gd+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[gd+1]   <= dv_v_ff[gd];
            dv_on_ff[gd+1]  <= dv_on_ff[gd];
            dv_led_ff[gd+1] <= dv_led_ff[gd];
         end
      end
   end

   // per channel datapath
   logic [7:0] chan_w [0:Channels-1];

   for (genvar gc = 0; gc < Channels; gc++) begin : g_chan
      sin_type     sx_ff [0:CordicSteps];
      sin_type     sy_ff [0:CordicSteps];
      sin_type     sz_ff [0:CordicSteps];
      logic        sf_ff [0:CordicSteps];
      logic [15:0] lift_ff;
      logic [31:0] prod_ff;
      logic [16:0] rem_ff [0:DivSteps];
      logic [7:0]  quo_ff [0:DivSteps];
      turn_type    a_w, a_fold;
      logic        flip_w;

      // fold the angle into a quarter turn each side of zero
      always_comb begin
         a_w    = md_ang_ff + chan_offset(gc);
         flip_w = a_w[15] ^ a_w[14];
         a_fold = flip_w ? (a_w ^ FoldMask) : a_w;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sx_ff[0] <= SineGain;
            sy_ff[0] <= '0;
            sz_ff[0] <= sin_type'($signed(a_fold));
            sf_ff[0] <= flip_w;
         end
      end

      // rotation steps
      for (genvar gk = 0; gk < CordicSteps; gk++) begin : g_rot
         sin_type xs, ys, step;
         always_comb begin
            xs   = sx_ff[gk] >>> gk;
            ys   = sy_ff[gk] >>> gk;
            step = sin_type'({1'b0, atan_turn(gk)});
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               sf_ff[gk+1] <= sf_ff[gk];
               if (sz_ff[gk] >= 0) begin
                  sx_ff[gk+1] <= sx_ff[gk] - ys;
                  sy_ff[gk+1] <= sy_ff[gk] + xs;
                  sz_ff[gk+1] <= sz_ff[gk] - step;
               end else begin
                  sx_ff[gk+1] <= sx_ff[gk] + ys;
                  sy_ff[gk+1] <= sy_ff[gk] - xs;
                  sz_ff[gk+1] <= sz_ff[gk] + step;
               end
            end
         end
      end

      // clamp, unfold and lift to 0..32768
      sin_type sy_clamp, sy_sign;
      logic signed [17:0] lift_w;
      always_comb begin
         sy_clamp = sy_ff[CordicSteps];
         if (sy_clamp > OneQ14) begin
            sy_clamp = OneQ14;
         end
         if (sy_clamp < -OneQ14) begin
            sy_clamp = -OneQ14;
         end
         sy_sign = sf_ff[CordicSteps] ? -sy_clamp : sy_clamp;
         lift_w  = 18'(sy_sign) + 18'(OneQ14);
      end

      // lift times falloff, then times 127 and drop the Q14 and Q8 scale
      logic [38:0] scaled_w;
      always_comb begin
         scaled_w = ({7'd0, prod_ff} << 7) - {7'd0, prod_ff};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            lift_ff   <= lift_w[15:0];
            prod_ff   <= 32'(lift_ff) * 32'(lf_fall_ff);
            rem_ff[0] <= scaled_w[38:22];
            quo_ff[0] <= '0;
         end
      end

      // restoring divide by radius, one quotient bit per stage
      for (genvar gd = 0; gd < DivSteps; gd++) begin : g_div
         logic [16:0] dvs;
         logic        fits;
         always_comb begin
            dvs  = 17'(radius_ff) << (DivSteps - 1 - gd);
            fits = (rem_ff[gd] >= dvs);
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[gd+1] <= fits ? rem_ff[gd] - dvs : rem_ff[gd];
               quo_ff[gd+1] <= {quo_ff[gd][6:0], fits};
            end
         end
      end

      always_comb begin
         if (!dv_on_ff[DivSteps]) begin
            chan_w[gc] = 8'd0;
         end else if (quo_ff[DivSteps] > ChanMax) begin
            chan_w[gc] = ChanMax;
         end else begin
            chan_w[gc] = quo_ff[DivSteps];
         end
      end
   end

   // output register
   logic        rsp_v_ff;
   logic [9:0]  rsp_led_ff;
   logic [7:0]  rsp_r_ff, rsp_g_ff, rsp_b_ff;

   assign adv = !rsp_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff   <= dv_v_ff[DivSteps];
         rsp_led_ff <= dv_led_ff[DivSteps];
         rsp_r_ff   <= chan_w[0];
         rsp_g_ff   <= chan_w[1];
         rsp_b_ff   <= chan_w[2];
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'd0, rsp_b_ff, rsp_g_ff, rsp_r_ff, rsp_led_ff};

   // checks
   `RSWIRL_ASSERT_NEXT(a_phase_step, req_tvalid && req_tready && req_tuser,
      phase_ff == $past(phase_ff + phase_step_ff), "phase did not advance on frame start")
   `RSWIRL_ASSERT_IMPLY(a_chan_range, rsp_tvalid,
      rsp_r_ff <= ChanMax && rsp_g_ff <= ChanMax && rsp_b_ff <= ChanMax,
      "channel above 254")
   `RSWIRL_ASSERT_IMPLY(a_led_dark, rsp_tvalid && (32'(rsp_led_ff) >= LED_COUNT),
      rsp_r_ff == 8'd0 && rsp_g_ff == 8'd0 && rsp_b_ff == 8'd0,
      "led outside the chain is lit")
   `RSWIRL_ASSERT_IMPLY(a_stall_blocks, rsp_tvalid && !rsp_tready, !req_tready,
      "item taken while output stalled")

endmodule
`default_nettype wire
